FILE: design/pvsq_pkg.sv
package pvsq_pkg;

   // Mode codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PROBE    = 3'd1;
   localparam logic [2:0] ST_RAMP     = 3'd2;
   localparam logic [2:0] ST_ACTIVE   = 3'd3;
   localparam logic [2:0] ST_COOLDOWN = 3'd4;

   localparam logic [1:0]  BAD_LIMIT      = 2'd3;
   localparam logic [15:0] VALID_POWER_MW = 16'd250;

   // Register file
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_V   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_V    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_V   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOADED_V  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_LUX  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MS  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_MS   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL_MS   = 4'd7;

   typedef struct packed {
      logic [15:0] start_voltage_mv;
      logic [15:0] stop_voltage_mv;
      logic [15:0] probe_min_voltage_mv;
      logic [15:0] loaded_min_voltage_mv;
      logic [15:0] wake_lux;
      logic [15:0] probe_hold_ms;
      logic [15:0] ramp_eval_ms;
      logic [15:0] cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic        sensor_good;
      logic        panel_good;
      logic [15:0] panel_voltage_mv;
      logic [15:0] panel_power_mw;
      logic [15:0] light_lux;
      logic [31:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic [2:0] fsm_state;
      logic       source_enabled;
      logic       source_available;
   } result_type;

endpackage

FILE: design/pvsq_csr.sv
module pvsq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [pvsq_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [15:0]                   wr_data,
   output pvsq_pkg::cfg_type             cfg
);
   import pvsq_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_voltage_mv      <= 16'd6200;
         cfg_ff.stop_voltage_mv       <= 16'd6000;
         cfg_ff.probe_min_voltage_mv  <= 16'd5200;
         cfg_ff.loaded_min_voltage_mv <= 16'd5500;
         cfg_ff.wake_lux              <= 16'd120;
         cfg_ff.probe_hold_ms         <= 16'd8000;
         cfg_ff.ramp_eval_ms          <= 16'd5000;
         cfg_ff.cooldown_ms           <= 16'd10000;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_START_V:  cfg_ff.start_voltage_mv      <= wr_data;
            CSR_STOP_V:   cfg_ff.stop_voltage_mv       <= wr_data;
            CSR_PROBE_V:  cfg_ff.probe_min_voltage_mv  <= wr_data;
            CSR_LOADED_V: cfg_ff.loaded_min_voltage_mv <= wr_data;
            CSR_WAKE_LUX: cfg_ff.wake_lux              <= wr_data;
            CSR_PROBE_MS: cfg_ff.probe_hold_ms         <= wr_data;
            CSR_RAMP_MS:  cfg_ff.ramp_eval_ms          <= wr_data;
            CSR_COOL_MS:  cfg_ff.cooldown_ms           <= wr_data;
            default: ;    // unmapped index: ignored
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pvsq_core.sv
module pvsq_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  pvsq_pkg::sample_type   sample,
   input  pvsq_pkg::cfg_type      cfg,
   output pvsq_pkg::result_type   result
);
   import pvsq_pkg::*;

   logic [2:0]  mode_ff,    mode_in;
   logic [31:0] entered_ff, entered_in;
   logic [1:0]  bad_ff,     bad_in;

   logic [31:0] elapsed;
   logic [1:0]  bad_inc;
   logic        start_ok;
   logic        bad;
   logic        loaded;

   assign elapsed = sample.now_ms - entered_ff;
   assign bad_inc = (bad_ff < BAD_LIMIT) ? bad_ff + 2'd1 : bad_ff;

   assign start_ok = sample.panel_good
                     && (sample.panel_voltage_mv > cfg.probe_min_voltage_mv)
                     && ((sample.panel_voltage_mv > cfg.start_voltage_mv)
                         || (sample.light_lux > cfg.wake_lux));
   assign bad      = !sample.panel_good
                     || (sample.panel_voltage_mv < cfg.stop_voltage_mv);
   assign loaded   = (sample.panel_voltage_mv > cfg.loaded_min_voltage_mv)
                     && ((sample.panel_power_mw > VALID_POWER_MW)
                         || (sample.panel_voltage_mv > cfg.start_voltage_mv));

   always_comb begin
      mode_in    = mode_ff;
      entered_in = entered_ff;
      bad_in     = bad_ff;
      if (!sample.sensor_good) begin
         // sensor fault: drop to idle but keep the entry time
         mode_in = ST_IDLE;
         bad_in  = 2'd0;
      end else begin
         unique case (mode_ff)
            ST_IDLE: begin
               bad_in = 2'd0;
               if (start_ok) begin
                  mode_in    = ST_PROBE;
                  entered_in = sample.now_ms;
               end
            end
            ST_PROBE: begin
               if (bad) begin
                  mode_in    = ST_COOLDOWN;
                  entered_in = sample.now_ms;
                  bad_in     = 2'd0;
               end else if (elapsed >= {16'd0, cfg.probe_hold_ms}) begin
                  mode_in    = ST_RAMP;
                  entered_in = sample.now_ms;
                  bad_in     = 2'd0;
               end
            end
            ST_RAMP: begin
               if (bad) begin
                  bad_in = bad_inc;
                  if (bad_inc >= BAD_LIMIT) begin
                     mode_in    = ST_COOLDOWN;
                     entered_in = sample.now_ms;
                     bad_in     = 2'd0;
                  end
               end else begin
                  bad_in = 2'd0;
                  if (elapsed >= {16'd0, cfg.ramp_eval_ms}) begin
                     mode_in    = loaded ? ST_ACTIVE : ST_COOLDOWN;
                     entered_in = sample.now_ms;
                  end
               end
            end
            ST_ACTIVE: begin
               if (bad) begin
                  bad_in = bad_inc;
                  if (bad_inc >= BAD_LIMIT) begin
                     mode_in    = ST_COOLDOWN;
                     entered_in = sample.now_ms;
                     bad_in     = 2'd0;
                  end
               end else begin
                  bad_in = 2'd0;
               end
            end
            ST_COOLDOWN: begin
               if (elapsed >= {16'd0, cfg.cooldown_ms}) begin
                  mode_in    = start_ok ? ST_PROBE : ST_IDLE;
                  entered_in = sample.now_ms;
                  bad_in     = 2'd0;
               end
            end
            default: begin
               mode_in = ST_IDLE;
               bad_in  = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ST_IDLE;
         entered_ff <= 32'd0;
         bad_ff     <= 2'd0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         entered_ff <= entered_in;
         bad_ff     <= bad_in;
      end
   end

   assign result.fsm_state        = mode_in;
   assign result.source_enabled   = (mode_in == ST_PROBE) || (mode_in == ST_RAMP)
                                    || (mode_in == ST_ACTIVE);
   assign result.source_available = (mode_in == ST_ACTIVE);

endmodule

FILE: design/pv_source_qualifier_fsm.sv
// Solar-panel source qualifier.
//
// Each request carries one panel sample (sensor/panel valid flags, voltage in
// mV, power in mW, light in lux and a free-running ms timestamp). The block
// steps a five-state mode machine (idle, probe, ramp, active, cooldown) and
// returns one response per request: the new mode plus source-enabled and
// source-available flags.
//
// Channels: req_* in, rsp_* out, both valid/ready. csr_* writes one of the
// eight 16-bit thresholds; csr_ready is always high. Write it only while idle.
//
// Path: an accepted request goes into the sample register, its response into
// the response register. Throughput: one request per cycle while responses
// are taken; the mode update is a single compare stage between those registers.
// Stall: while rsp_valid waits on rsp_ready, one more request can sit in the
// sample register; after that req_ready drops until the response is taken.
// Reset: synchronous, clears both stages, mode goes idle, entry time zero and
// thresholds return to their defaults.
module pv_source_qualifier_fsm (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_sensor_good,
   input  logic                          req_panel_good,
   input  logic [15:0]                   req_panel_voltage_mv,
   input  logic [15:0]                   req_panel_power_mw,
   input  logic [15:0]                   req_light_lux,
   input  logic [31:0]                   req_now_ms,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_fsm_state,
   output logic                          rsp_source_enabled,
   output logic                          rsp_source_available,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pvsq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);
   import pvsq_pkg::*;

   cfg_type    cfg;
   sample_type sample_ff, sample_in;
   logic       s1_valid_ff, s1_valid_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   // --- register file ---
   assign csr_ready = 1'b1;

   pvsq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // --- handshake ---
   // The sample stage moves on whenever the response slot is empty or is
   // being emptied this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign sample_in.sensor_good      = req_sensor_good;
   assign sample_in.panel_good       = req_panel_good;
   assign sample_in.panel_voltage_mv = req_panel_voltage_mv;
   assign sample_in.panel_power_mw   = req_panel_power_mw;
   assign sample_in.light_lux        = req_light_lux;
   assign sample_in.now_ms           = req_now_ms;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // --- sample register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= sample_in;
      end
   end

   // --- mode machine ---
   pvsq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // --- response register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fsm_state        = rsp_ff.fsm_state;
   assign rsp_source_enabled   = rsp_ff.source_enabled;
   assign rsp_source_available = rsp_ff.source_available;

endmodule

FILE: design/pvsq_checker.sv
module pvsq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_fsm_state,
   input logic       rsp_source_enabled,
   input logic       rsp_source_available
);
   import pvsq_pkg::*;

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // both stages are empty after reset, so a request is taken at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fsm_state)
         && $stable(rsp_source_enabled) && $stable(rsp_source_available))
      else $error("stalled response changed");

   // flags follow the reported mode
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_source_available == (rsp_fsm_state == ST_ACTIVE))
         && (rsp_source_enabled == ((rsp_fsm_state == ST_PROBE)
             || (rsp_fsm_state == ST_RAMP) || (rsp_fsm_state == ST_ACTIVE))))
      else $error("source flags disagree with mode");

endmodule

bind pv_source_qualifier_fsm pvsq_checker u_pvsq_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_fsm_state        (rsp_fsm_state),
   .rsp_source_enabled   (rsp_source_enabled),
   .rsp_source_available (rsp_source_available)
);

FILE: dv/pv_source_qualifier_fsm_tb.sv
`timescale 1ns / 1ps

// Each request is one panel sample. A local copy of the mode machine runs
// on every accepted request and queues the status it expects back; the
// response monitor compares that status field by field with what the block
// returns. Register writes go in only with nothing in flight.
module pv_source_qualifier_fsm_tb;
   import pvsq_pkg::*;

   localparam int unsigned CSR_COUNT   = 8;     // indexes at and above this are unused
   localparam int unsigned STALL_LIMIT = 4000;  // cycles with no handshake at all
   localparam int unsigned REPORT_MAX  = 10;

   // Directed rows either carry a status typed in by hand or are left to the
   // local mode machine.
   localparam logic CHK_PRED  = 1'b0;
   localparam logic CHK_TYPED = 1'b1;

   typedef struct packed {
      logic       typed;
      logic [2:0] exp_state;
      sample_type s;
   } stim_row_type;

   // Row layout: check kind, typed mode, sensor ok, panel ok, mV, mW, lux, ms.
   // Default thresholds apply throughout.
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      // sensor fault straight out of reset
      {CHK_TYPED, ST_IDLE,  1'b0, 1'b0, 16'd0,     16'd0,     16'd0,     32'd0},
      // dead panel, no start
      {CHK_TYPED, ST_IDLE,  1'b1, 1'b1, 16'd0,     16'd0,     16'd0,     32'd0},
      // everything at full scale starts a probe
      {CHK_TYPED, ST_PROBE, 1'b1, 1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  32'd100},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd5000},
      // probe hold met exactly
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd8100},
      // one bad sample in ramp, then a good one clears the count
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd100,   16'd0,     16'd0,     32'd9000},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd9500},
      // ramp evaluation passes on voltage alone
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd13100},
      // three bad panel readings in active: saturate and fall to cooldown
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b0, 16'd6500,  16'd0,     16'd0,     32'd14000},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b0, 16'd6500,  16'd0,     16'd0,     32'd14001},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b0, 16'd6500,  16'd0,     16'd0,     32'd14002},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd15000},
      // timestamp runs backwards: elapsed wraps huge, re-probe on light
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd5300,  16'd0,     16'd200,   32'd10},
      // weak sample during probe
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd5900,  16'd0,     16'd200,   32'd20},
      // sensor fault in cooldown, all else at full scale
      {CHK_TYPED, ST_IDLE,  1'b0, 1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF},
      // start on light just over the wake level
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd5300,  16'd0,     16'd121,   32'd100},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6100,  16'd0,     16'd0,     32'hFFFF_FFFF},
      // power-only load level, but under the stop voltage: counts as bad in ramp
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd5600,  16'd251,   16'd0,     32'd5000},
      {CHK_TYPED, ST_IDLE,  1'b0, 1'b1, 16'd6500,  16'd0,     16'd0,     32'd6000},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6300,  16'd0,     16'd0,     32'd0},
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6300,  16'd0,     16'd0,     32'd8000},
      // loaded check fails: power at its limit, voltage under the start level
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd6000,  16'd250,   16'd0,     32'd13000},
      // cooldown expires with no start possible
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b0, 16'd0,     16'd0,     16'd0,     32'd23000},
      // voltage equal to the probe minimum is not enough
      {CHK_PRED,  ST_IDLE,  1'b1, 1'b1, 16'd5200,  16'd0,     16'hFFFF,  32'd23001}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_sensor_good;
   logic        req_panel_good;
   logic [15:0] req_panel_voltage_mv;
   logic [15:0] req_panel_power_mw;
   logic [15:0] req_light_lux;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_fsm_state;
   logic        rsp_source_enabled;
   logic        rsp_source_available;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   // Local copy of the thresholds and the mode machine
   cfg_type     thr;
   logic [2:0]  model_mode;
   logic [31:0] model_entered_ms;
   logic [1:0]  model_bad_run;
   logic [31:0] sample_clock_ms;

   result_type  pending_status[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned fault_count;
   int unsigned samples_sent;
   int unsigned responses_checked;
   int unsigned reg_writes;
   int unsigned mode_hits[5];
   int unsigned quiet_cycles;

   pv_source_qualifier_fsm dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sensor_good      (req_sensor_good),
      .req_panel_good       (req_panel_good),
      .req_panel_voltage_mv (req_panel_voltage_mv),
      .req_panel_power_mw   (req_panel_power_mw),
      .req_light_lux        (req_light_lux),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_fsm_state        (rsp_fsm_state),
      .rsp_source_enabled   (rsp_source_enabled),
      .rsp_source_available (rsp_source_available),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Status as reported for a given mode
   function automatic result_type status_of(input logic [2:0] mode);
      result_type r;
      r.fsm_state        = mode;
      r.source_enabled   = (mode == ST_PROBE) || (mode == ST_RAMP) || (mode == ST_ACTIVE);
      r.source_available = (mode == ST_ACTIVE);
      return r;
   endfunction

   function automatic void enter_mode(input logic [2:0] mode, input logic [31:0] now);
      model_mode       = mode;
      model_entered_ms = now;
      model_bad_run    = '0;
   endfunction

   // Bad sample in ramp or active: count up to the limit, then cool down
   function automatic void tally_bad(input logic [31:0] now);
      if (model_bad_run < BAD_LIMIT) model_bad_run = model_bad_run + 2'd1;
      if (model_bad_run >= BAD_LIMIT) enter_mode(ST_COOLDOWN, now);
   endfunction

   // One step of the mode machine for an accepted sample
   function automatic result_type qualify_sample(input sample_type s);
      logic [31:0] elapsed;
      logic        start_ok;
      logic        poor;
      logic        loaded;
      elapsed  = s.now_ms - model_entered_ms;
      start_ok = s.panel_good && (s.panel_voltage_mv > thr.probe_min_voltage_mv) &&
                 ((s.panel_voltage_mv > thr.start_voltage_mv) || (s.light_lux > thr.wake_lux));
      poor     = !s.panel_good || (s.panel_voltage_mv < thr.stop_voltage_mv);
      if (!s.sensor_good) begin
         // entry time is deliberately left alone here
         model_mode    = ST_IDLE;
         model_bad_run = '0;
      end else begin
         case (model_mode)
            ST_IDLE: begin
               model_bad_run = '0;
               if (start_ok) begin
                  model_mode       = ST_PROBE;
                  model_entered_ms = s.now_ms;
               end
            end
            ST_PROBE: begin
               if (poor) enter_mode(ST_COOLDOWN, s.now_ms);
               else if (elapsed >= thr.probe_hold_ms) enter_mode(ST_RAMP, s.now_ms);
            end
            ST_RAMP: begin
               if (poor) begin
                  tally_bad(s.now_ms);
               end else begin
                  model_bad_run = '0;
                  if (elapsed >= thr.ramp_eval_ms) begin
                     loaded = (s.panel_voltage_mv > thr.loaded_min_voltage_mv) &&
                              ((s.panel_power_mw > VALID_POWER_MW) ||
                               (s.panel_voltage_mv > thr.start_voltage_mv));
                     model_mode       = loaded ? ST_ACTIVE : ST_COOLDOWN;
                     model_entered_ms = s.now_ms;
                  end
               end
            end
            ST_ACTIVE: begin
               if (poor) tally_bad(s.now_ms);
               else model_bad_run = '0;
            end
            ST_COOLDOWN: begin
               if (elapsed >= thr.cooldown_ms)
                  enter_mode(start_ok ? ST_PROBE : ST_IDLE, s.now_ms);
            end
            default: begin
               model_mode    = ST_IDLE;
               model_bad_run = '0;
            end
         endcase
      end
      return status_of(model_mode);
   endfunction

   // A level a couple of units either side of a threshold
   function automatic logic [15:0] near(input logic [15:0] level);
      return level + 16'($urandom_range(4)) - 16'd2;
   endfunction

   // Random sample, mostly healthy so that long runs reach ramp and active
   function automatic sample_type draw_sample();
      sample_type  s;
      logic [15:0] floor_v;
      floor_v = thr.start_voltage_mv;
      if (thr.stop_voltage_mv > floor_v) floor_v = thr.stop_voltage_mv;
      if (thr.loaded_min_voltage_mv > floor_v) floor_v = thr.loaded_min_voltage_mv;
      if (thr.probe_min_voltage_mv > floor_v) floor_v = thr.probe_min_voltage_mv;
      s.sensor_good = ($urandom_range(99) >= 3);
      s.panel_good  = ($urandom_range(99) >= 6);
      case ($urandom_range(9))
         0: s.panel_voltage_mv = near(thr.start_voltage_mv);
         1: s.panel_voltage_mv = near(thr.stop_voltage_mv);
         2: s.panel_voltage_mv = near(thr.probe_min_voltage_mv);
         3: s.panel_voltage_mv = near(thr.loaded_min_voltage_mv);
         4: s.panel_voltage_mv = 16'($urandom);
         default: s.panel_voltage_mv = (floor_v > 16'd63000) ? 16'hFFFF :
                                       floor_v + 16'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(3))
         0: s.panel_power_mw = near(VALID_POWER_MW);
         1: s.panel_power_mw = 16'($urandom);
         default: s.panel_power_mw = 16'($urandom_range(251, 65535));
      endcase
      case ($urandom_range(3))
         0: s.light_lux = near(thr.wake_lux);
         1: s.light_lux = 16'($urandom);
         2: s.light_lux = 16'd0;
         default: s.light_lux = thr.wake_lux + 16'($urandom_range(1, 500));
      endcase
      // timestamp mostly creeps forward, sometimes stalls or jumps anywhere
      case ($urandom_range(19))
         0: sample_clock_ms = $urandom;
         1: sample_clock_ms = sample_clock_ms;
         2, 3, 4: sample_clock_ms = sample_clock_ms + $urandom_range(0, 70000);
         default: sample_clock_ms = sample_clock_ms + $urandom_range(1, 2500);
      endcase
      s.now_ms = sample_clock_ms;
      return s;
   endfunction

   // Offer one request; on acceptance queue what should come back
   task automatic push_sample(input sample_type s, input logic typed,
                              input logic [2:0] exp_state);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_sensor_good      <= s.sensor_good;
      req_panel_good       <= s.panel_good;
      req_panel_voltage_mv <= s.panel_voltage_mv;
      req_panel_power_mw   <= s.panel_power_mw;
      req_light_lux        <= s.light_lux;
      req_now_ms           <= s.now_ms;
      do @(posedge clock); while (!req_ready);
      predicted = qualify_sample(s);
      pending_status.push_back(typed ? status_of(exp_state) : predicted);
      samples_sent++;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) push_sample(draw_sample(), CHK_PRED, ST_IDLE);
   endtask

   // Drop valid and let every response come home before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_START_V:  thr.start_voltage_mv      = val;
         CSR_STOP_V:   thr.stop_voltage_mv       = val;
         CSR_PROBE_V:  thr.probe_min_voltage_mv  = val;
         CSR_LOADED_V: thr.loaded_min_voltage_mv = val;
         CSR_WAKE_LUX: thr.wake_lux              = val;
         CSR_PROBE_MS: thr.probe_hold_ms         = val;
         CSR_RAMP_MS:  thr.ramp_eval_ms          = val;
         CSR_COOL_MS:  thr.cooldown_ms           = val;
         default: ;  // unused index, write dropped
      endcase
      reg_writes++;
   endtask

   // Full threshold set, plus one write to an unused index that must be dropped
   task automatic load_thresholds(input cfg_type c);
      logic [CSR_IDX_W-1:0] stray_idx;
      stray_idx = CSR_IDX_W'(CSR_COUNT + $urandom_range(CSR_COUNT - 1));
      csr_write(CSR_START_V,  c.start_voltage_mv);
      csr_write(CSR_STOP_V,   c.stop_voltage_mv);
      csr_write(CSR_PROBE_V,  c.probe_min_voltage_mv);
      csr_write(CSR_LOADED_V, c.loaded_min_voltage_mv);
      csr_write(CSR_WAKE_LUX, c.wake_lux);
      csr_write(CSR_PROBE_MS, c.probe_hold_ms);
      csr_write(CSR_RAMP_MS,  c.ramp_eval_ms);
      csr_write(CSR_COOL_MS,  c.cooldown_ms);
      csr_write(stray_idx,    16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response checker: oldest expectation against every accepted response
   always @(posedge clock) begin : check_responses
      result_type seen;
      result_type want;
      logic       differs;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.fsm_state        = rsp_fsm_state;
         seen.source_enabled   = rsp_source_enabled;
         seen.source_available = rsp_source_available;
         if (pending_status.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("%0t: response with nothing outstanding: mode %0d en %0b av %0b",
                        $realtime, seen.fsm_state, seen.source_enabled,
                        seen.source_available);
         end else begin
            want = pending_status.pop_front();
            responses_checked++;
            if (want.fsm_state <= ST_COOLDOWN) mode_hits[want.fsm_state]++;
            differs = (seen.fsm_state != want.fsm_state) ||
                      (seen.source_enabled != want.source_enabled) ||
                      (seen.source_available != want.source_available);
            if (differs) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("%0t: response %0d mismatch: mode %0d/%0d en %0b/%0b av %0b/%0b %s",
                           $realtime, responses_checked, want.fsm_state, seen.fsm_state,
                           want.source_enabled, seen.source_enabled,
                           want.source_available, seen.source_available,
                           "(expected/actual)");
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake on any channel is a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d quiet cycles, %0d responses outstanding",
                  quiet_cycles, pending_status.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type c;
      req_valid            <= 1'b0;
      req_sensor_good      <= 1'b0;
      req_panel_good       <= 1'b0;
      req_panel_voltage_mv <= '0;
      req_panel_power_mw   <= '0;
      req_light_lux        <= '0;
      req_now_ms           <= '0;
      csr_valid            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      reset                <= 1'b1;
      quiet_cycles         = 0;
      fault_count          = 0;
      samples_sent         = 0;
      responses_checked    = 0;
      reg_writes           = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      send_idle_pct        = 18;
      recv_idle_pct        = 52;

      // Thresholds as they come out of reset
      thr.start_voltage_mv      = 16'd6200;
      thr.stop_voltage_mv       = 16'd6000;
      thr.probe_min_voltage_mv  = 16'd5200;
      thr.loaded_min_voltage_mv = 16'd5500;
      thr.wake_lux              = 16'd120;
      thr.probe_hold_ms         = 16'd8000;
      thr.ramp_eval_ms          = 16'd5000;
      thr.cooldown_ms           = 16'd10000;
      model_mode       = ST_IDLE;
      model_entered_ms = '0;
      model_bad_run    = '0;
      sample_clock_ms  = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed walk on the reset thresholds
      foreach (DIRECTED_ROWS[i])
         push_sample(DIRECTED_ROWS[i].s, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp_state);
      sample_clock_ms = 32'd30000;
      run_random(160);
      settle();

      // Thresholds anywhere in range
      c = cfg_type'({$urandom, $urandom, $urandom, $urandom});
      load_thresholds(c);
      run_random(130);
      settle();

      // Roles of the two sides swapped for the extreme settings
      send_idle_pct = 52;
      recv_idle_pct = 18;

      // All zero: every hold time expires at once, only panel faults are bad
      load_thresholds('0);
      run_random(110);
      settle();

      // Maximum hold times; start on light only and the load check never passes
      c.start_voltage_mv      = 16'hFFFF;
      c.stop_voltage_mv       = 16'd0;
      c.probe_min_voltage_mv  = 16'd0;
      c.loaded_min_voltage_mv = 16'hFFFF;
      c.wake_lux              = 16'd0;
      c.probe_hold_ms         = 16'hFFFF;
      c.ramp_eval_ms          = 16'hFFFF;
      c.cooldown_ms           = 16'hFFFF;
      load_thresholds(c);
      run_random(110);
      settle();

      // Full rate on both sides, thresholds scattered around their defaults
      send_idle_pct = 0;
      recv_idle_pct = 0;
      c.start_voltage_mv      = 16'd6200 + 16'($urandom_range(400)) - 16'd200;
      c.stop_voltage_mv       = 16'd6000 + 16'($urandom_range(400)) - 16'd200;
      c.probe_min_voltage_mv  = 16'd5200 + 16'($urandom_range(400)) - 16'd200;
      c.loaded_min_voltage_mv = 16'd5500 + 16'($urandom_range(400)) - 16'd200;
      c.wake_lux              = 16'($urandom_range(0, 400));
      c.probe_hold_ms         = 16'($urandom_range(0, 9000));
      c.ramp_eval_ms          = 16'($urandom_range(0, 9000));
      c.cooldown_ms           = 16'($urandom_range(0, 12000));
      load_thresholds(c);
      run_random(190);

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_status.size() != 0) fault_count++;

      $display("Sent %0d samples, checked %0d responses, %0d register writes",
               samples_sent, responses_checked, reg_writes);
      $display("Responses per mode: idle %0d probe %0d ramp %0d active %0d cooldown %0d",
               mode_hits[ST_IDLE], mode_hits[ST_PROBE], mode_hits[ST_RAMP],
               mode_hits[ST_ACTIVE], mode_hits[ST_COOLDOWN]);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures", fault_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/pvsq_pkg.sv
design/pvsq_csr.sv
design/pvsq_core.sv
design/pv_source_qualifier_fsm.sv
design/pvsq_checker.sv
dv/pv_source_qualifier_fsm_tb.sv
